FILE: hw/rtl/pl1d_pkg.sv
// Shared constants for the 1-D max/average pooling unit.
// Holds register index codes, defaults and limits; no dependencies.
package pl1d_pkg;

    localparam int MAX_KERNEL_DEF  = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // results per input beat at most
    localparam int RESULT_CAP = 16;

    // geometry arithmetic width (signed)
    localparam int GEO_W = 24;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INLEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLEN = 3'd5;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

endpackage

FILE: hw/rtl/pl1d_cell.sv
// One cell of the sample ring: holds one stored sample.
// Takes a new sample on write, or its neighbor's value on rotate.
module pl1d_cell #(
    parameter int SB = 16
) (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic          i_wr,
    input  logic [SB-1:0] i_nbr,
    input  logic [SB-1:0] i_din,
    output logic [SB-1:0] o_q
);
    logic [SB-1:0] r_q;

    // load on write, else take neighbor on rotate
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q <= i_din;
        end else if (i_shift) begin
            r_q <= i_nbr;
        end
    end

    assign o_q = r_q;
endmodule

FILE: hw/rtl/pl1d_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Used for the average quotient; no dependencies.
module pl1d_div #(
    parameter int DW = 24,
    parameter int VW = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_dvs,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   w_t;
    logic          w_ge;

    assign w_t  = {r_rem, r_quo[DW-1]};
    assign w_ge = w_t >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-subtract step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], w_ge};
            r_rem <= w_ge ? VW'(w_t - {1'b0, r_dvs}) : w_t[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

FILE: hw/rtl/pool_1d_max_avg_unit.sv
// 1-D max/average pooling over a sample stream; ring of sample cells plus one divider.
// Per input beat the sequencer works out each window's geometry and start slot, rotates the whole
// ring past the head cell to scan the window, and in average mode runs the divider for the quotient.
// One beat is taken at a time; a finished result waits in the output register.
// Reset (synchronous, active low) restores register defaults and clears row
// position and window count; stored samples are not cleared.
module pool_1d_max_avg_unit #(
    parameter int MAX_KERNEL  = pl1d_pkg::MAX_KERNEL_DEF,
    parameter int SAMPLE_BITS = pl1d_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pl1d_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pl1d_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // sample stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0]         i_s_axis_tdata,  // [SB-1:0] sample
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [SAMPLE_BITS+15:0]        o_m_axis_tdata,  // {window_index, pooled}
    output logic                           o_m_axis_tlast   // row_done
);
    import pl1d_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int MK   = MAX_KERNEL;
    localparam int KW   = $clog2(MK + 1);
    localparam int SLW  = $clog2(MK);
    localparam int SUMW = SB + KW;
    localparam int DVW  = (SUMW > GEO_W) ? SUMW : GEO_W;
    localparam int NW   = $clog2(RESULT_CAP + 1);

    // window start width and its reciprocal for the slot of a start position
    localparam int LOW = 21;
    localparam int RCW = LOW + 1;
    localparam logic [RCW-1:0] LO_RCP =
        RCW'(((64'd1 << (LOW + SLW)) + 64'(MK) - 64'd1) / 64'(MK));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GEOA = 3'd1;
    localparam logic [2:0] S_GEOB = 3'd2;
    localparam logic [2:0] S_MODK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DIVQ = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    // configuration registers
    logic        r_mode;
    logic [4:0]  r_ksz, r_strd;
    logic [3:0]  r_padc;
    logic [15:0] r_inlen, r_outlen;

    // per-beat settings and row state
    logic [2:0]    r_st;
    logic          r_md, r_last;
    logic [KW-1:0] r_k;
    logic [4:0]    r_s;
    logic [3:0]    r_pd;
    logic [15:0]   r_len, r_olen, r_pos, r_nw;
    logic [SLW-1:0] r_wslot, r_rot, r_loslot, r_sc;
    logic [NW-1:0] r_n;
    logic [20:0]   r_prod;
    logic signed [GEO_W-1:0] r_cnt_in;
    logic [KW-1:0] r_dvs;
    logic          r_dvok, r_neg;
    logic signed [SUMW-1:0] r_acc;
    logic [SB-1:0] r_res;

    // output register
    logic          r_ov, r_olast;
    logic [SB-1:0] r_opool;
    logic [15:0]   r_oidx;

    // effective settings
    logic [7:0]    w_k8, w_kc;
    logic [KW-1:0] w_k;
    logic [3:0]    w_pd;
    logic [15:0]   w_len;
    logic          w_in_acc, w_cfg_acc;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;
    assign w_k8 = (r_ksz == 5'd0) ? 8'd1 : {3'b0, r_ksz};
    assign w_kc = (w_k8 > 8'(MK)) ? 8'(MK) : w_k8;
    assign w_k  = w_kc[KW-1:0];
    assign w_pd = ({4'b0, r_padc} < (w_kc - 8'd1)) ? r_padc : 4'((w_kc - 8'd1));
    assign w_len = (r_inlen == 16'd0) ? 16'd1 : r_inlen;

    // window geometry
    logic signed [GEO_W-1:0] w_st, w_en_c, w_en, w_lo, w_dv, w_kx, w_pdx, w_lenx;
    logic w_brk, w_cut;
    assign w_kx   = GEO_W'(r_k);
    assign w_pdx  = GEO_W'(r_pd);
    assign w_lenx = GEO_W'(r_len);
    assign w_st   = GEO_W'(r_prod) - w_pdx;
    assign w_en_c = w_st + w_kx;
    assign w_en   = (w_en_c < w_lenx) ? w_en_c : w_lenx;
    assign w_lo   = (w_st > 0) ? w_st : '0;
    assign w_brk  = !r_last && ((w_en - 1) > GEO_W'(r_pos));
    assign w_cut  = (r_nw == r_olen - 16'd1) && ((w_en + w_pdx) < (w_st + w_kx));
    assign w_dv   = w_cut ? (w_pdx + w_en - w_st) : w_kx;

    // slot of the window start: quotient by reciprocal, then remainder
    logic [LOW-1:0]     r_lo, r_lq, w_lrem;
    logic [LOW+RCW-1:0] w_lprod;
    logic               r_mph;
    assign w_lprod = (LOW+RCW)'(r_lo) * (LOW+RCW)'(LO_RCP);
    assign w_lrem  = r_lo - LOW'(r_lq * LOW'(MK));

    // sample ring
    logic [SB-1:0]  w_q [MK];
    logic [SLW-1:0] w_widx;
    logic           w_shift;
    assign w_widx  = (r_wslot >= r_rot) ? SLW'(r_wslot - r_rot)
                                        : SLW'(r_wslot + SLW'(MK) - r_rot);
    assign w_shift = (r_st == S_SCAN);

    for (genvar j = 0; j < MK; j++) begin : g_cell
        pl1d_cell #(.SB(SB)) u_cell (
            .i_clk  (i_clk),
            .i_shift(w_shift),
            .i_wr   (w_in_acc && (w_widx == SLW'(j))),
            .i_nbr  (w_q[(j + 1) % MK]),
            .i_din  (i_s_axis_tdata),
            .o_q    (w_q[j])
        );
    end

    // scan step: head cell holds slot r_rot
    logic [SLW:0]            w_d;
    logic signed [GEO_W-1:0] w_dx;
    logic                    w_inwin;
    logic signed [SUMW-1:0]  w_head, n_acc;
    logic [SUMW-1:0]         w_mag;
    assign w_d = (r_rot >= r_loslot) ? (SLW+1)'(r_rot - r_loslot)
                                     : (SLW+1)'({1'b0, r_rot} + (SLW+1)'(MK) - {1'b0, r_loslot});
    assign w_dx    = GEO_W'(w_d);
    assign w_inwin = w_dx < r_cnt_in;
    assign w_head  = {{(SUMW-SB){w_q[0][SB-1]}}, w_q[0]};

    always_comb begin
        n_acc = r_acc;
        if (w_inwin) begin
            if (r_md == MODE_AVG) begin
                n_acc = r_acc + w_head;
            end else if (w_head > r_acc) begin
                n_acc = w_head;
            end
        end
    end
    assign w_mag = n_acc[SUMW-1] ? SUMW'(-n_acc) : SUMW'(n_acc);

    // average divider
    logic           w_dstart, w_ddone;
    logic [DVW-1:0] w_dvd, w_quo;
    logic           w_scan_end;
    assign w_scan_end = (r_st == S_SCAN) && (r_sc == SLW'(MK - 1));
    assign w_dstart = w_scan_end && (r_md == MODE_AVG) && r_dvok;
    assign w_dvd    = DVW'(w_mag);

    pl1d_div #(.DW(DVW), .VW(KW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_dvd  (w_dvd),
        .i_dvs  (r_dvs),
        .o_done (w_ddone),
        .o_quo  (w_quo)
    );

    logic w_emit;
    assign w_emit = (r_st == S_EMIT) && (!r_ov || i_m_axis_tready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MAX;
            r_ksz    <= 5'd2;
            r_strd   <= 5'd2;
            r_padc   <= 4'd0;
            r_inlen  <= 16'd16;
            r_outlen <= 16'd8;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                CFG_KERNEL: r_ksz    <= i_cfg_data[4:0];
                CFG_STRIDE: r_strd   <= i_cfg_data[4:0];
                CFG_PAD:    r_padc   <= i_cfg_data[3:0];
                CFG_INLEN:  r_inlen  <= i_cfg_data;
                CFG_OUTLEN: r_outlen <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and row control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_pos   <= '0;
            r_nw    <= '0;
            r_wslot <= '0;
            r_rot   <= '0;
            r_n     <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_n  <= '0;
                        r_st <= S_GEOA;
                    end
                end
                S_GEOA: begin
                    r_st <= ((r_nw < r_olen) && (r_n < NW'(RESULT_CAP))) ? S_GEOB : S_FIN;
                end
                S_GEOB: begin
                    r_st <= w_brk ? S_FIN : S_MODK;
                end
                S_MODK: begin
                    if (r_mph) begin
                        r_sc <= '0;
                        r_st <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rot <= (r_rot == SLW'(MK - 1)) ? '0 : r_rot + 1'b1;
                    r_sc  <= r_sc + 1'b1;
                    if (w_scan_end) begin
                        r_st <= ((r_md == MODE_AVG) && r_dvok) ? S_DIVQ : S_EMIT;
                    end
                end
                S_DIVQ: begin
                    if (w_ddone) begin
                        r_st <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_nw <= r_nw + 1'b1;
                        r_n  <= r_n + 1'b1;
                        r_st <= S_GEOA;
                    end
                end
                S_FIN: begin
                    if (r_last) begin
                        r_pos   <= '0;
                        r_nw    <= '0;
                        r_wslot <= '0;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_wslot <= (r_wslot == SLW'(MK - 1)) ? '0 : r_wslot + 1'b1;
                    end
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_md   <= r_mode;
            r_k    <= w_k;
            r_s    <= (r_strd == 5'd0) ? 5'd1 : r_strd;
            r_pd   <= w_pd;
            r_len  <= w_len;
            r_olen <= r_outlen;
            r_last <= (17'(r_pos) + 17'd1) >= 17'(w_len);
        end
        if (r_st == S_GEOA) begin
            r_prod <= 21'(r_nw) * 21'(r_s);
        end
        if (r_st == S_GEOB) begin
            r_cnt_in <= w_en - w_lo;
            r_dvs    <= KW'(w_dv);
            r_dvok   <= w_dv > 0;
            r_lo     <= LOW'(w_lo);
            r_mph    <= 1'b0;
        end
        if (r_st == S_MODK) begin
            r_mph <= 1'b1;
            if (!r_mph) begin
                r_lq <= LOW'(w_lprod >> (LOW + SLW));
            end else begin
                r_loslot <= SLW'(w_lrem);
                r_acc    <= (r_md == MODE_AVG) ? '0 : -(SUMW'(1) << (SB - 1));
            end
        end
        if (r_st == S_SCAN) begin
            r_acc <= n_acc;
            if (w_scan_end) begin
                r_neg <= n_acc[SUMW-1];
                r_res <= (r_md == MODE_AVG) ? '0 : n_acc[SB-1:0];
            end
        end
        if ((r_st == S_DIVQ) && w_ddone) begin
            r_res <= r_neg ? SB'(-w_quo[SB-1:0]) : w_quo[SB-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_opool <= r_res;
            r_oidx  <= r_nw;
            r_olast <= (r_nw == r_olen - 16'd1)
                    || (r_last && (r_n == NW'(RESULT_CAP - 1)));
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_st == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {r_oidx, r_opool};
    assign o_m_axis_tlast  = r_olast;
endmodule

FILE: hw/rtl/pl1d_chk.sv
// Port-level checks for the pooling unit, bound to the top level.
// Depends on pl1d_pkg and pool_1d_max_avg_unit.
module pl1d_chk #(
    parameter int SAMPLE_BITS = pl1d_pkg::SAMPLE_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_cfg_ready,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [SAMPLE_BITS+15:0]        o_m_axis_tdata,
    input logic                           o_m_axis_tlast
);
    // one beat at a time: ready drops right after a beat
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while a beat is in work");

    // nothing to show right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

    // config channel never stalls
    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config channel stalled");
endmodule

bind pool_1d_max_avg_unit pl1d_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_pl1d_chk (.*);

FILE: verif/tb_pool_1d_max_avg_unit.sv
// Testbench for pool_1d_max_avg_unit: streams sample rows, predicts each pooled window.
// Depends on pl1d_pkg and the pooling unit RTL.
`timescale 1ns / 1ps

module tb_pool_1d_max_avg_unit;
    import pl1d_pkg::*;

    localparam int SB    = 16;
    localparam int MAXK  = 16;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [SB-1:0] pooled;
        logic [15:0]   win;
        logic          done;
    } window_t;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [2:0]      i_cfg_index;
    logic [15:0]     i_cfg_data;
    logic            i_s_axis_tvalid;
    logic            o_s_axis_tready;
    logic [SB-1:0]   i_s_axis_tdata;
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready;
    logic [SB+15:0]  o_m_axis_tdata;
    logic            o_m_axis_tlast;

    pool_1d_max_avg_unit dut (.*);

    // shadow registers and window state
    logic        pm_mode;
    int          pm_kernel, pm_stride, pm_pad, pm_inlen, pm_outlen;
    int          hist [MAXK];
    int          row_pos, next_win;

    window_t     window_q[$];
    int          errors;
    int          cycles;
    int          hold_off;
    bit          sender_bursty;

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall pattern, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 3) != 0) || (cycles[9:8] == 2'b00);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        window_t got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[SB-1:0], o_m_axis_tdata[SB+15:SB], o_m_axis_tlast};
            if (window_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h win %0d", got.pooled, got.win);
            end else begin
                want = window_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp val %h win %0d last %b, got %h %0d %b",
                                 want.pooled, want.win, want.done,
                                 got.pooled, got.win, got.done);
                end
            end
        end
    end

    // compute one window from the sample history
    function automatic logic [SB-1:0] pool_value(int h, int k, int s, int pad, int len,
                                                 int olen);
        longint acc, dv;
        int     start, stop, lo;
        start = h * s - pad;
        stop  = (start + k < len) ? start + k : len;
        lo    = (start > 0) ? start : 0;
        if (!pm_mode) begin
            acc = -(1 << (SB - 1));
            for (int i = lo; i < stop; i++)
                if (hist[i % MAXK] > acc) acc = hist[i % MAXK];
            return acc[SB-1:0];
        end
        acc = 0;
        for (int i = lo; i < stop; i++) acc += hist[i % MAXK];
        dv = k;
        if (h == olen - 1 && stop + pad < start + k) dv = pad + stop - start;
        if (dv < 1) return '0;
        acc = acc / dv;
        return acc[SB-1:0];
    endfunction

    // advance the predicted row by one sample and queue finished windows
    function automatic void predict_sample(logic [SB-1:0] smp);
        int k, s, pad, len, n, start, stop, h;
        bit last;
        k   = (pm_kernel == 0) ? 1 : ((pm_kernel > MAXK) ? MAXK : pm_kernel);
        s   = (pm_stride == 0) ? 1 : pm_stride;
        pad = (pm_pad < k - 1) ? pm_pad : k - 1;
        len = (pm_inlen == 0) ? 1 : pm_inlen;
        last = (row_pos + 1 >= len);
        n = 0;
        hist[row_pos % MAXK] = int'($signed(smp));
        while (next_win < pm_outlen && n < RESULT_CAP) begin
            window_t w;
            h = next_win;
            start = h * s - pad;
            stop  = (start + k < len) ? start + k : len;
            if (!last && stop - 1 > row_pos) break;
            w.pooled = pool_value(h, k, s, pad, len, pm_outlen);
            w.win    = h[15:0];
            w.done   = (h == pm_outlen - 1);
            window_q.push_back(w);
            n++;
            next_win = (next_win + 1) & 16'hffff;
        end
        if (last) begin
            if (n > 0) window_q[$].done = 1'b1;
            row_pos  = 0;
            next_win = 0;
        end else begin
            row_pos = (row_pos + 1) & 16'hffff;
        end
    endfunction

    // send one sample beat, with random gaps between bursts when sender_bursty is set; valid stays up after the beat
    task automatic send_sample(logic [SB-1:0] smp);
        if (sender_bursty && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_sample(smp);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (window_q.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:   pm_mode   = val[0];
            CFG_KERNEL: pm_kernel = int'(val[4:0]);
            CFG_STRIDE: pm_stride = int'(val[4:0]);
            CFG_PAD:    pm_pad    = int'(val[3:0]);
            CFG_INLEN:  pm_inlen  = int'(val);
            CFG_OUTLEN: pm_outlen = int'(val);
            default: ;
        endcase
    endtask

    // set a whole geometry; only called when the unit is idle
    task automatic set_geometry(logic md, int k, int s, int pad, int len, int olen);
        i_s_axis_tvalid <= 1'b0;
        write_reg(CFG_MODE, {15'b0, md});
        write_reg(CFG_KERNEL, 16'(k));
        write_reg(CFG_STRIDE, 16'(s));
        write_reg(CFG_PAD, 16'(pad));
        write_reg(CFG_INLEN, 16'(len));
        write_reg(CFG_OUTLEN, 16'(olen));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int natural_windows(int k, int s, int pad, int len);
        int p, n;
        p = (pad < k - 1) ? pad : k - 1;
        n = (len + p - k) / s + 1;
        if (len + p - k < 0) n = 1;
        return (n > 16) ? 16 : ((n < 1) ? 1 : n);
    endfunction

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_row(int len);
        for (int i = 0; i < len; i++) send_sample(rand_sample());
    endtask

    // default settings out of reset: max mode, kernel 2, stride 2
    task automatic test_reset_defaults();
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_row(14);
        drain_results();
    endtask

    // field extremes, padding, short final window, more pending than the cap and no windows
    task automatic test_directed();
        set_geometry(MODE_AVG, 4, 3, 2, 6, 3);
        send_sample(16'h7fff); send_sample(16'h7fff); send_sample(16'h8000);
        send_sample(16'h0001); send_sample(16'hffff); send_sample(16'h0100);
        drain_results();
        set_geometry(MODE_MAX, 16, 16, 15, 3, 4);   // empty windows and pad clamp
        send_row(3);
        drain_results();
        set_geometry(MODE_AVG, 1, 1, 0, 2, 20);     // more pending windows than the cap
        send_row(2);
        drain_results();
        set_geometry(MODE_MAX, 3, 1, 1, 4, 0);      // no windows at all
        send_row(4);
        drain_results();
    endtask

    // long receiver stall while samples keep coming, then a full pause
    task automatic test_backpressure();
        set_geometry(MODE_AVG, 2, 1, 0, 24, 23);
        hold_off = 400;
        send_row(24);
        drain_results();
    endtask

    // random geometries with random rows
    task automatic test_random_rows();
        int k, s, pad, len, olen, sent;
        sent = 0;
        while (sent < 100) begin
            k    = $urandom_range(1, 16);
            s    = $urandom_range(1, 16);
            pad  = $urandom_range(0, 15);
            len  = $urandom_range(1, 20);
            olen = natural_windows(k, s, pad, len);
            if ($urandom_range(0, 4) == 0) olen = $urandom_range(1, 16);
            if ($urandom_range(0, 9) == 0) begin
                k = 16; s = 16; len = 16;
            end
            set_geometry(1'($urandom_range(0, 1)), k, s, pad, len, olen);
            repeat ($urandom_range(1, 3)) begin
                send_row(len);
                sent += len;
            end
            drain_results();
        end
        set_geometry(MODE_MAX, 2, 2, 0, 16'hffff, 16'hffff); // top of the length fields
        send_row(5);
        drain_results();
        set_geometry(MODE_MAX, 2, 2, 0, 16, 8);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        sender_bursty = 1'b1;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        pm_mode = MODE_MAX; pm_kernel = 2; pm_stride = 2; pm_pad = 0;
        pm_inlen = 16; pm_outlen = 8;
        row_pos = 0; next_win = 0;
        foreach (hist[i]) hist[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed();
        test_backpressure();
        sender_bursty = 1'b0;
        test_random_rows();
        sender_bursty = 1'b1;
        test_random_rows();
        drain_results();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: pool_1d_max_avg_unit.f
hw/rtl/pl1d_pkg.sv
hw/rtl/pl1d_cell.sv
hw/rtl/pl1d_div.sv
hw/rtl/pool_1d_max_avg_unit.sv
hw/rtl/pl1d_chk.sv
verif/tb_pool_1d_max_avg_unit.sv
